FILE: sv/qodo_pkg.sv
// shared types, constants and helper functions for the quadrature odometry block
package qodo_pkg;

	// fixed design constants, settled by the field widths of the ports
	localparam int MaxBatch    = 128;
	localparam int CordicSteps = 16;

	// pi in Q2.28 and the cordic gain compensation in Q1.30
	localparam logic [29:0] Pi28 = 30'd843314857;
	localparam logic signed [33:0] GainQ30 = 34'sd652032874;

	// command codes
	localparam logic OpEdge = 1'b0;
	localparam logic OpSet  = 1'b1;

	// wheel codes
	localparam logic WheelLeft  = 1'b0;
	localparam logic WheelRight = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CfgBatch  = 2'd0;
	localparam logic [1:0] CfgRadius = 2'd1;
	localparam logic [1:0] CfgBase   = 2'd2;
	localparam logic [1:0] CfgTicks  = 2'd3;

	typedef struct packed {
		logic               op;
		logic               wheel;
		logic               phase;
		logic               level_a;
		logic               level_b;
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [15:0] new_heading;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [15:0] out_heading;
	} pose_t;

	typedef struct packed {
		logic [7:0]  batch_size;
		logic [15:0] wheel_radius;
		logic [19:0] wheel_base;
		logic [16:0] ticks_per_rev;
	} cfg_t;

	// work handed from the front to the back
	typedef struct packed {
		logic               load;
		logic signed [8:0]  right;
		logic signed [8:0]  left;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        heading;
	} job_t;

	// arctangent table, 2^32 units per turn
	function automatic logic [31:0] atan_q32(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// clamp a widened position to the signed 32-bit range
	function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -34'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: sv/qodo_front.sv
// front end: takes encoder and set-position commands, keeps counts, queues work
module qodo_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  qodo_pkg::cmd_t  cmd,
	input  logic [7:0]      batch_size,
	input  logic            queue_full,
	output logic            push,
	output qodo_pkg::job_t  job
);
	import qodo_pkg::*;

	logic signed [8:0] right_q, left_q;
	logic [7:0]        edge_q;
	logic              accept;
	logic signed [8:0] step;
	logic signed [8:0] right_nx, left_nx;
	logic [7:0]        edge_nx, limit;
	logic              close;

	assign cmd_stall = queue_full;
	assign accept    = cmd_valid & ~queue_full;

	// direction of one edge and the updated wheel and edge counts
	always_comb begin
		step = ((cmd.level_a ^ cmd.level_b) ^ cmd.phase) ? 9'sd1 : -9'sd1;
		right_nx = right_q;
		left_nx  = left_q;
		if (cmd.wheel == WheelRight) begin
			right_nx = right_q + step;
		end else begin
			left_nx = left_q - step;
		end
		edge_nx = edge_q + 8'd1;
	end

	// batch limit clamped to one and the largest batch
	always_comb begin
		if (batch_size == 8'd0) begin
			limit = 8'd1;
		end else if (batch_size > 8'(MaxBatch)) begin
			limit = 8'(MaxBatch);
		end else begin
			limit = batch_size;
		end
	end

	assign close = (cmd.op == OpEdge) && (edge_nx >= limit);
	assign push  = accept & ((cmd.op == OpSet) | close);

	// job contents
	always_comb begin
		job.load    = (cmd.op == OpSet);
		job.right   = right_nx;
		job.left    = left_nx;
		job.x       = cmd.new_x;
		job.y       = cmd.new_y;
		job.heading = cmd.new_heading;
	end

	// count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= '0;
			left_q  <= '0;
			edge_q  <= '0;
		end else if (accept && cmd.op == OpEdge) begin
			if (close) begin
				right_q <= '0;
				left_q  <= '0;
				edge_q  <= '0;
			end else begin
				right_q <= right_nx;
				left_q  <= left_nx;
				edge_q  <= edge_nx;
			end
		end
	end

endmodule

FILE: sv/qodo_fifo.sv
// two-entry job queue between front and back
module qodo_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  qodo_pkg::job_t wr_job,
	input  logic           pop,
	output qodo_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);
	import qodo_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign full   = (fill_q == 2'd2);
	assign empty  = (fill_q == 2'd0);
	assign rd_job = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: sv/qodo_div.sv
// restoring divider, one quotient bit per cycle
module qodo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [54:0] num,
	input  logic [44:0] den,
	output logic        done,
	output logic [54:0] quo
);
	import qodo_pkg::*;

	logic [54:0] num_q;
	logic [44:0] den_q;
	logic [44:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [45:0] trial;
	logic        fits;

	assign trial = {rem_q, num_q[54]};
	assign fits  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = num_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 45'(trial - {1'b0, den_q}) : trial[44:0];
			num_q <= {num_q[53:0], fits};
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd54;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: sv/qodo_back.sv
// back end: heading and distance division, cordic rotation, position update, set-position loads
module qodo_back (
	input  logic            clk,
	input  logic            arst_n,
	input  qodo_pkg::cfg_t  cfg,
	input  logic            queue_empty,
	input  qodo_pkg::job_t  job,
	output logic            pop,
	output logic            pose_valid,
	input  logic            pose_stall,
	output qodo_pkg::pose_t pose
);
	import qodo_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MUL1  = 9'b000000010,
		S_MUL2  = 9'b000000100,
		S_DIVA  = 9'b000001000,
		S_DIVB  = 9'b000010000,
		S_CORD  = 9'b000100000,
		S_MULXY = 9'b001000000,
		S_SUM   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic signed [9:0]  diff_q, sum_q;
	logic [24:0]        th_prod_q, d_prod_q;
	logic               th_neg_q, d_neg_q;
	logic [36:0]        den_th_q;
	logic [54:0]        d_big_q;
	logic signed [21:0] dist_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic [4:0]         step_q;
	logic signed [55:0] px_q, py_q;
	logic signed [31:0] x_pos_q, y_pos_q;
	logic [15:0]        heading_q;
	pose_t              pose_q;
	logic               pose_valid_q;

	logic               div_start, div_done;
	logic [54:0]        div_num, div_quo;
	logic [44:0]        div_den;
	logic signed [9:0]  diff_mag, sum_mag;
	logic signed [33:0] xs, ys, at;
	logic [31:0]        ang, ang_f;
	logic signed [33:0] cos_v, sin_v;
	logic signed [55:0] dx, dy;
	logic signed [21:0] q_s;
	logic               out_free;

	assign pop        = (state_q == S_IDLE) && !queue_empty;
	assign pose       = pose_q;
	assign pose_valid = pose_valid_q;
	assign out_free   = !pose_valid_q || !pose_stall;

	qodo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// divider operand selection
	always_comb begin
		div_start = 1'b0;
		div_num   = 55'({th_prod_q, 16'b0}) + 55'(den_th_q >> 1);
		div_den   = 45'(den_th_q);
		case (state_q)
			S_MUL2: begin
				div_start = 1'b1;
			end
			S_DIVA: begin
				div_start = div_done;
				div_num   = d_big_q + 55'({cfg.ticks_per_rev, 27'b0});
				div_den   = {cfg.ticks_per_rev, 28'b0};
			end
			default: div_start = 1'b0;
		endcase
	end

	// magnitudes, cordic step terms, angle folding and rounding of the final products
	always_comb begin
		diff_mag = diff_q[9] ? -diff_q : diff_q;
		sum_mag  = sum_q[9] ? -sum_q : sum_q;
		xs       = cx_q >>> step_q;
		ys       = cy_q >>> step_q;
		at       = $signed({2'b00, atan_q32(step_q)});
		ang      = {heading_q, 16'b0};
		ang_f    = (ang[31] ^ ang[30]) ? {~ang[31], ang[30:0]} : ang;
		cos_v    = flip_q ? -cx_q : cx_q;
		sin_v    = flip_q ? -cy_q : cy_q;
		dx       = (px_q + 56'sd536870912) >>> 30;
		dy       = (py_q + 56'sd536870912) >>> 30;
		q_s      = $signed(div_quo[21:0]);
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			x_pos_q   <= '0;
			y_pos_q   <= '0;
			heading_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!queue_empty) begin
						diff_q <= 10'(job.right) - 10'(job.left);
						sum_q  <= 10'(job.right) + 10'(job.left);
						if (job.load) begin
							x_pos_q   <= job.x;
							y_pos_q   <= job.y;
							heading_q <= job.heading;
							state_q   <= S_OUT;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					th_prod_q <= 25'(diff_mag[8:0]) * 25'(cfg.wheel_radius);
					th_neg_q  <= diff_q[9];
					d_prod_q  <= 25'(sum_mag[8:0]) * 25'(cfg.wheel_radius);
					d_neg_q   <= sum_q[9];
					den_th_q  <= 37'(cfg.wheel_base) * 37'(cfg.ticks_per_rev);
					state_q   <= S_MUL2;
				end
				S_MUL2: begin
					d_big_q <= 55'(d_prod_q) * 55'(Pi28);
					state_q <= S_DIVA;
				end
				S_DIVA: begin
					if (div_done) begin
						heading_q <= heading_q +
							(th_neg_q ? 16'(-div_quo[15:0]) : div_quo[15:0]);
						state_q <= S_DIVB;
					end
				end
				S_DIVB: begin
					if (div_done) begin
						dist_q  <= d_neg_q ? -q_s : q_s;
						cx_q    <= GainQ30;
						cy_q    <= '0;
						cz_q    <= $signed({{2{ang_f[31]}}, ang_f});
						flip_q  <= ang[31] ^ ang[30];
						step_q  <= '0;
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + at;
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(CordicSteps - 1)) begin
						state_q <= S_MULXY;
					end
				end
				S_MULXY: begin
					px_q    <= 56'(dist_q) * 56'(cos_v);
					py_q    <= 56'(dist_q) * 56'(sin_v);
					state_q <= S_SUM;
				end
				S_SUM: begin
					x_pos_q <= sat_pos(34'(x_pos_q) + dx[33:0]);
					y_pos_q <= sat_pos(34'(y_pos_q) + dy[33:0]);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			pose_q.out_x       <= x_pos_q;
			pose_q.out_y       <= y_pos_q;
			pose_q.out_heading <= heading_q;
		end
	end

	// output valid, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			pose_valid_q <= 1'b1;
		end else if (!pose_stall) begin
			pose_valid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/quadrature_odometry.sv
// quadrature odometry: a single-edge command is taken per cycle unless cmd_stall is high;
// edges without a result finish in the front end at once. A batch-closing edge, once
// taken by the back end, runs a heading and a distance division on the shared divider
// (55 quotient bits each), 16 cordic steps and the position update. A set-position
// command loads position and heading and goes straight to output. Two jobs may queue.
// Reset clears counts, position, heading and queue and loads the register defaults.
module quadrature_odometry (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  qodo_pkg::cmd_t  cmd,
	output logic            pose_valid,
	input  logic            pose_stall,
	output qodo_pkg::pose_t pose,
	input  logic            wr_en,
	input  logic [1:0]      wr_index,
	input  logic [19:0]     wr_data
);
	import qodo_pkg::*;

	cfg_t cfg_q;
	logic push, pop, full, empty;
	job_t wr_job, rd_job;

	// configuration registers, bad radius, base and tick values ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.batch_size    <= 8'd64;
			cfg_q.wheel_radius  <= 16'd5244;
			cfg_q.wheel_base    <= 20'd29651;
			cfg_q.ticks_per_rev <= 17'd4096;
		end else if (wr_en) begin
			case (wr_index)
				CfgBatch: cfg_q.batch_size <= wr_data[7:0];
				CfgRadius: begin
					if (wr_data[15:0] != 16'd0) begin
						cfg_q.wheel_radius <= wr_data[15:0];
					end
				end
				CfgBase: begin
					if (wr_data != 20'd0) begin
						cfg_q.wheel_base <= wr_data;
					end
				end
				CfgTicks: begin
					if (wr_data[16:0] != 17'd0 && wr_data[6:0] == 7'd0) begin
						cfg_q.ticks_per_rev <= wr_data[16:0];
					end
				end
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	qodo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.batch_size (cfg_q.batch_size),
		.queue_full (full),
		.push       (push),
		.job        (wr_job)
	);

	qodo_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.full   (full),
		.empty  (empty)
	);

	qodo_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.queue_empty (empty),
		.job         (rd_job),
		.pop         (pop),
		.pose_valid  (pose_valid),
		.pose_stall  (pose_stall),
		.pose        (pose)
	);

endmodule
